// ===== rtl/core/dec2fx_pkg.sv =====
// package for the decimal text to fixed-point converter
// holds character codes, the sequencer state type and the shared structs
// no dependencies
package dec2fx_pkg;

  // largest supported number of fraction digits
  localparam int unsigned MaxScale = 18;

  localparam int ScaleWidth = 5;
  localparam int CharWidth  = 8;
  localparam int ValueWidth = 64;
  localparam int DigitWidth = 4;
  // value times ten plus a digit needs three extra bits, plus one for the carry
  localparam int ProdWidth  = ValueWidth + 4;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2d;
  localparam logic [CharWidth-1:0] CharPlus  = 8'h2b;
  localparam logic [CharWidth-1:0] CharPoint = 8'h2e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  is_sign;
    logic                  is_minus;
    logic                  is_point;
    logic                  is_digit;
    logic [DigitWidth-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic                  over;
    logic [ValueWidth-1:0] value;
  } mul10_result_t;

endpackage

// ===== rtl/core/decimal_text_to_fixed_point.sv =====
// top level of the decimal text to fixed-point converter
// depends on dec2fx_pkg, dec2fx_classify and dec2fx_mul10
//
// usage:
//   input channel: character and last_char, transferred when in_valid is high
//   and in_stall is low. one decimal number is a run of characters, the last
//   one flagged by last_char.
//   output channel: fixed_value and ok, transferred when out_valid is high and
//   out_stall is low. one result per number, fixed_value is 0 when ok is 0.
//   config channel: cfg_data sets the number of fraction digits on a transfer
//   with cfg_valid and cfg_ready; write it only while no number is in flight.
// characters: each one is taken in, then gets one step of the shared
//   multiply-by-ten unit; in_stall is high during that step, so the next
//   character is not taken before the step is done.
// result: after the last character, the missing fraction digits P (0 to 18)
//   are padded by the same unit one per cycle, then the output register loads.
// stall: a finished result sits in the output register; characters of the
//   next number keep flowing, and only the following result waits for it.
// reset: synchronous, clears the number state, the scale register to 0 and
//   the output valid.
module decimal_text_to_fixed_point
  import dec2fx_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // character input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CharWidth-1:0]         character,
  input  logic                         last_char,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ValueWidth-1:0] fixed_value,
  output logic                         ok,
  // scale register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ScaleWidth-1:0]        cfg_data
);

  state_t state, state_next;

  // scale register
  logic [ScaleWidth-1:0] scale;

  // captured character
  logic [CharWidth-1:0] char_q;
  logic                 last_q;

  // per-number state
  logic [ValueWidth-1:0] magnitude, magnitude_next;
  logic [ScaleWidth-1:0] fraction_count, fraction_count_next;
  logic after_point, after_point_next;
  logic seen_digit, seen_digit_next;
  logic is_negative, is_negative_next;
  logic at_start, at_start_next;
  logic failed, failed_next;

  logic load_out;
  logic out_valid_next;
  logic scale_ok;

  char_class_t   cls;
  mul10_result_t step;
  logic [DigitWidth-1:0] unit_digit;

  dec2fx_classify u_classify (
    .ch  (char_q),
    .cls (cls)
  );

  // padding steps feed a zero digit
  assign unit_digit = (state == ST_CHAR) ? cls.digit : '0;

  dec2fx_mul10 u_mul10 (
    .mag   (magnitude),
    .digit (unit_digit),
    .neg   (is_negative),
    .res   (step)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign scale_ok  = (scale <= ScaleWidth'(MaxScale));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and per-number state updates
  always_comb begin
    state_next          = state;
    magnitude_next      = magnitude;
    fraction_count_next = fraction_count;
    after_point_next    = after_point;
    seen_digit_next     = seen_digit;
    is_negative_next    = is_negative;
    at_start_next       = at_start;
    failed_next         = failed;
    load_out            = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHAR;
        end
      end

      ST_CHAR: begin
        if (!failed) begin
          at_start_next = 1'b0;
          if (at_start && cls.is_sign) begin
            is_negative_next = cls.is_minus;
            if (last_q) begin
              failed_next = 1'b1;
            end
          end else if (cls.is_point) begin
            // needs a digit before it, one after it, and only one of them
            if (after_point || !seen_digit || last_q) begin
              failed_next = 1'b1;
            end else begin
              after_point_next = 1'b1;
            end
          end else if (!cls.is_digit) begin
            failed_next = 1'b1;
          end else begin
            seen_digit_next = 1'b1;
            if (after_point && (fraction_count >= scale)) begin
              // digits past the scale must be zeros
              if (cls.digit != '0) begin
                failed_next = 1'b1;
              end
            end else if (step.over) begin
              failed_next = 1'b1;
            end else begin
              magnitude_next = step.value;
              if (after_point) begin
                fraction_count_next = ScaleWidth'(fraction_count + 1'b1);
              end
            end
          end
        end
        state_next = last_q ? ST_FIN : ST_IDLE;
      end

      ST_FIN: begin
        if (failed || !seen_digit || !scale_ok) begin
          failed_next = 1'b1;
          state_next  = ST_OUT;
        end else if (fraction_count < scale) begin
          // pad one missing fraction digit
          if (step.over) begin
            failed_next = 1'b1;
            state_next  = ST_OUT;
          end else begin
            magnitude_next      = step.value;
            fraction_count_next = ScaleWidth'(fraction_count + 1'b1);
          end
        end else begin
          state_next = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out            = 1'b1;
          magnitude_next      = '0;
          fraction_count_next = '0;
          after_point_next    = 1'b0;
          seen_digit_next     = 1'b0;
          is_negative_next    = 1'b0;
          at_start_next       = 1'b1;
          failed_next         = 1'b0;
          state_next          = ST_IDLE;
        end
      end
    endcase
  end

  // number state
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude      <= '0;
      fraction_count <= '0;
      after_point    <= 1'b0;
      seen_digit     <= 1'b0;
      is_negative    <= 1'b0;
      at_start       <= 1'b1;
      failed         <= 1'b0;
    end else begin
      magnitude      <= magnitude_next;
      fraction_count <= fraction_count_next;
      after_point    <= after_point_next;
      seen_digit     <= seen_digit_next;
      is_negative    <= is_negative_next;
      at_start       <= at_start_next;
      failed         <= failed_next;
    end
  end

  // character capture on an input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_q <= character;
      last_q <= last_char;
    end
  end

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= '0;
    end else if (cfg_valid && cfg_ready) begin
      scale <= cfg_data;
    end
  end

  // output register
  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok <= !failed;
      if (failed) begin
        fixed_value <= '0;
      end else if (is_negative) begin
        fixed_value <= $signed('0 - magnitude);
      end else begin
        fixed_value <= $signed(magnitude);
      end
    end
  end

endmodule

// ===== rtl/core/dec2fx_classify.sv =====
// character decoder for the decimal text to fixed-point converter
// depends on dec2fx_pkg
module dec2fx_classify
  import dec2fx_pkg::*;
(
  input  logic [CharWidth-1:0] ch,
  output char_class_t          cls
);

  always_comb begin
    cls.is_sign  = (ch == CharMinus) || (ch == CharPlus);
    cls.is_minus = (ch == CharMinus);
    cls.is_point = (ch == CharPoint);
    cls.is_digit = (ch >= CharZero) && (ch <= CharNine);
    // '0'..'9' are 0x30..0x39, low nibble is the digit
    cls.digit    = ch[DigitWidth-1:0];
  end

endmodule

// ===== rtl/core/dec2fx_mul10.sv =====
// shared multiply-by-ten, add-digit and range-compare unit
// depends on dec2fx_pkg
module dec2fx_mul10
  import dec2fx_pkg::*;
(
  input  logic [ValueWidth-1:0] mag,
  input  logic [DigitWidth-1:0] digit,
  input  logic                  neg,
  output mul10_result_t         res
);

  logic [ProdWidth-1:0] prod;
  logic [ProdWidth-1:0] limit;

  // mag*10 + digit as (mag<<3) + (mag<<1) + digit
  assign prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0}
              + {{(ProdWidth-DigitWidth){1'b0}}, digit};

  // 2^63 for negative numbers, 2^63-1 otherwise
  assign limit = {4'b0000, neg, {(ValueWidth-1){~neg}}};

  assign res.over  = (prod > limit);
  assign res.value = prod[ValueWidth-1:0];

endmodule

// ===== rtl/core/dec2fx_checker.sv =====
// port-level checks for the decimal text to fixed-point converter
// depends on dec2fx_pkg; bound to decimal_text_to_fixed_point
module dec2fx_checker
  import dec2fx_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [ValueWidth-1:0] fixed_value,
  input logic                         ok
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fixed_value) && $stable(ok))
    else $error("result changed while stalled");

  // a failed number reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> fixed_value == '0)
    else $error("failed result is not zero");

  // the input stalls after every character transfer while the character is worked on
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind decimal_text_to_fixed_point dec2fx_checker u_dec2fx_checker (.*);

// ===== dv/tb_decimal_text_to_fixed_point.sv =====
// testbench for decimal_text_to_fixed_point: streams decimal texts, predicts each
// scaled result in a behavioral converter and checks every output transfer
// depends on dec2fx_pkg and the decimal_text_to_fixed_point rtl
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_point;
  import dec2fx_pkg::*;

  // quiet cycles allowed before the run is declared hung
  localparam int unsigned HangLimit   = 2000;
  // settling wait once every character is taken and every result seen
  localparam int unsigned DrainCycles = 24;
  // characters generated per random phase
  localparam int unsigned PhaseChars  = 135;

  typedef struct {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } text_char_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         ok;
  } fixed_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [CharWidth-1:0]         character = '0;
  logic                         last_char = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [ValueWidth-1:0] fixed_value;
  logic                         ok;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ScaleWidth-1:0]        cfg_data = '0;

  // characters waiting to be sent, and results waiting to come out
  text_char_t    pending_chars[$];
  fixed_result_t expected_values[$];

  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  // no idling on either side while set
  bit          quiet          = 1'b0;

  // scale register copy, follows every config transfer
  logic [ScaleWidth-1:0] scale_setting = '0;

  // converter state for the number in progress
  logic [ValueWidth-1:0] num_magnitude      = '0;
  logic [ScaleWidth-1:0] num_fraction_count = '0;
  bit                    num_after_point    = 1'b0;
  bit                    num_seen_digit     = 1'b0;
  bit                    num_negative       = 1'b0;
  bit                    num_at_start       = 1'b1;
  bit                    num_failed         = 1'b0;

  decimal_text_to_fixed_point u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .character   (character),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fixed_value (fixed_value),
    .ok          (ok),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // largest magnitude allowed for the sign of the current number
  function automatic logic [ValueWidth-1:0] magnitude_cap(input bit negative);
    return negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  endfunction

  function automatic logic [ValueWidth-1:0] ten_power(input int n);
    logic [ValueWidth-1:0] p;
    p = 64'd1;
    repeat (n) p = p * 64'd10;
    return p;
  endfunction

  // end of a number: pad missing fraction digits, then queue the result
  task automatic close_number(input logic [ScaleWidth-1:0] scale);
    bit                    good;
    logic [ValueWidth-1:0] cap;
    fixed_result_t         res;
    good = !num_failed && num_seen_digit && (scale <= MaxScale);
    cap  = magnitude_cap(num_negative);
    for (int i = 0; i < MaxScale && good && num_fraction_count < scale; i++) begin
      if (num_magnitude > cap / 64'd10) begin
        good = 1'b0;
        break;
      end
      num_magnitude      = num_magnitude * 64'd10;
      num_fraction_count = num_fraction_count + 1'b1;
    end
    if (good && num_fraction_count < scale) good = 1'b0;
    res.value = good ? (num_negative ? -num_magnitude : num_magnitude) : '0;
    res.ok    = good;
    expected_values.insert(expected_values.size(), res);
    // back to the idle state for the next number
    num_magnitude      = '0;
    num_fraction_count = '0;
    num_after_point    = 1'b0;
    num_seen_digit     = 1'b0;
    num_negative       = 1'b0;
    num_at_start       = 1'b1;
    num_failed         = 1'b0;
  endtask

  // one accepted character, with the scale in effect at that transfer
  task automatic take_text_char(input logic [CharWidth-1:0] ch, input bit last_flag,
                                input logic [ScaleWidth-1:0] scale);
    logic [ValueWidth-1:0] digit;
    logic [ValueWidth-1:0] cap;
    bit                    done;
    done  = num_failed;
    digit = ValueWidth'(ch - CharZero);
    // a leading sign is only taken as the very first character
    if (!done && num_at_start) begin
      num_at_start = 1'b0;
      if (ch == CharMinus || ch == CharPlus) begin
        num_negative = (ch == CharMinus);
        // sign alone is not a number
        if (last_flag) num_failed = 1'b1;
        done = 1'b1;
      end
    end
    if (!done && ch == CharPoint) begin
      // second point, no digit before it, or point at the very end
      if (num_after_point || !num_seen_digit || last_flag) num_failed = 1'b1;
      else num_after_point = 1'b1;
      done = 1'b1;
    end
    if (!done && (ch < CharZero || ch > CharNine)) begin
      num_failed = 1'b1;
      done       = 1'b1;
    end
    if (!done) begin
      num_seen_digit = 1'b1;
      if (num_after_point && num_fraction_count >= scale) begin
        // digits past the scale may only be zeros
        if (ch != CharZero) num_failed = 1'b1;
      end else begin
        cap = magnitude_cap(num_negative);
        if (num_magnitude > (cap - digit) / 64'd10) begin
          num_failed = 1'b1;
        end else begin
          num_magnitude = num_magnitude * 64'd10 + digit;
          if (num_after_point) num_fraction_count = num_fraction_count + 1'b1;
        end
      end
    end
    if (last_flag) close_number(scale);
  endtask

  // ---------------------------------------------------------------------------
  // character driver
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : drive_chars
    text_char_t nxt;
    bit         take_next;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take_next = !in_valid;
      if (in_valid && !in_stall) begin
        // transfer of the character presented since the last edge
        take_text_char(character, last_char, scale_setting);
        accepted_count++;
        take_next = 1'b1;
        send_gap  = idle_length();
      end
      if (take_next) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          nxt = pending_chars.pop_front();
          in_valid  <= 1'b1;
          character <= nxt.ch;
          last_char <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input fixed_result_t want,
                               input fixed_result_t got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch (%s): expected value %0d ok %0b, got value %0d ok %0b",
               what, want.value, want.ok, got.value, got.ok);
  endtask

  always @(posedge clk) begin : watch_results
    fixed_result_t got;
    fixed_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.value = fixed_value;
        got.ok    = ok;
        if (expected_values.size() == 0) begin
          want = '0;
          note_mismatch("no result pending", want, got);
        end else begin
          want = expected_values.pop_front();
          if (got.value !== want.value) note_mismatch("fixed_value", want, got);
          if (got.ok !== want.ok) note_mismatch("ok", want, got);
        end
      end
      // random backpressure, none in quiet stretches
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_length();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // hang detection: any transfer on any channel resets the count
  // ---------------------------------------------------------------------------

  initial begin : hang_watch
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HangLimit) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** decimal_text_to_fixed_point: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_char(input logic [CharWidth-1:0] ch, input logic last);
    text_char_t item;
    item.ch   = ch;
    item.last = last;
    pending_chars.insert(pending_chars.size(), item);
    pushed_count++;
  endtask

  task automatic queue_text(input logic [CharWidth-1:0] txt[$]);
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic queue_string(input string s);
    logic [CharWidth-1:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
    queue_text(txt);
  endtask

  // one random number text; mostly well formed, some near the range limits,
  // the rest a jumble of digits, points, signs and arbitrary bytes
  task automatic queue_number(input logic [ScaleWidth-1:0] scale);
    logic [CharWidth-1:0]  txt[$];
    logic [ValueWidth-1:0] q;
    string                 digits;
    int                    kind, r, int_len, frac_len, span, f, i;
    bit                    negative;
    kind = $urandom_range(0, 99);
    if (kind < 18 && scale <= MaxScale) begin
      // scaled value lands within one step of the signed limit
      negative = $urandom_range(0, 1);
      f        = $urandom_range(0, scale);
      q        = magnitude_cap(negative) / ten_power(scale - f) +
                 64'($urandom_range(0, 2)) - 64'd1;
      digits   = $sformatf("%0d", q);
      if (negative) txt.insert(txt.size(), CharMinus);
      else if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), CharPlus);
      for (i = 0; i < digits.len(); i++) begin
        if (f > 0 && i > 0 && i == digits.len() - f) txt.insert(txt.size(), CharPoint);
        txt.insert(txt.size(), digits[i]);
      end
      // trailing zeros after the fraction digits are harmless
      if (f > 0 && digits.len() > f)
        repeat ($urandom_range(0, 2)) txt.insert(txt.size(), CharZero);
    end else if (kind < 82) begin
      r = $urandom_range(0, 3);
      if (r == 0) txt.insert(txt.size(), CharMinus);
      else if (r == 1) txt.insert(txt.size(), CharPlus);
      r = $urandom_range(0, 99);
      int_len = (r < 70) ? $urandom_range(1, 3) :
                (r < 90) ? $urandom_range(4, 12) : $urandom_range(13, 21);
      repeat (int_len)
        txt.insert(txt.size(), CharZero + CharWidth'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) begin
        txt.insert(txt.size(), CharPoint);
        span     = (scale > MaxScale) ? 20 : int'(scale);
        frac_len = $urandom_range(1, span + 3);
        for (i = 0; i < frac_len; i++) begin
          // past the scale mostly zeros, now and then a stray digit
          if (i >= scale && $urandom_range(0, 6) != 0)
            txt.insert(txt.size(), CharZero);
          else
            txt.insert(txt.size(), CharZero + CharWidth'($urandom_range(0, 9)));
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 25) txt.insert(txt.size(), CharZero + CharWidth'($urandom_range(0, 9)));
        else if (r < 35) txt.insert(txt.size(), CharPoint);
        else if (r < 43) txt.insert(txt.size(), CharMinus);
        else if (r < 50) txt.insert(txt.size(), CharPlus);
        else txt.insert(txt.size(), CharWidth'($urandom_range(0, 255)));
      end
    end
    queue_text(txt);
  endtask

  // every character taken and every result seen, then let the block settle
  task automatic wait_drained();
    while (accepted_count != pushed_count || expected_values.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // only called at a clock edge with the block idle
  task automatic write_scale(input logic [ScaleWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    scale_setting = value;
  endtask

  initial begin : run_test
    logic [ScaleWidth-1:0] scale_plan[$];
    int unsigned           phase_start;
    scale_plan = '{5'd18, 5'd1, 5'd31, 5'd2, 5'd19, 5'd6, 5'd0, 5'd17,
                   ScaleWidth'($urandom_range(0, MaxScale)),
                   ScaleWidth'($urandom_range(0, 31)), 5'd18, 5'd3, 5'd12};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed texts at the reset scale of zero
    queue_string("-");     // sign alone
    queue_string("+1");
    queue_string("2.0");   // extra zero past the scale
    queue_string("1.5");   // nonzero digit past the scale
    queue_string(".5");    // point before any digit
    queue_string("5.");    // point as the final character
    queue_string("1..2");  // second point
    queue_string("1-");    // sign after the first character
    queue_string("07");
    queue_char(8'h00, 1'b1);
    queue_char(8'hff, 1'b1);
    wait_drained();

    // random phases, each under its own scale; some without any idling
    foreach (scale_plan[p]) begin
      write_scale(scale_plan[p]);
      quiet       = (p % 4 == 2);
      phase_start = pushed_count;
      while (pushed_count - phase_start < PhaseChars) queue_number(scale_setting);
      wait_drained();
    end

    if (error_count == 0 && expected_values.size() == 0)
      $display("** decimal_text_to_fixed_point: PASSED **");
    else
      $display("** decimal_text_to_fixed_point: FAILED **");
    $finish;
  end

endmodule

// ===== decimal_text_to_fixed_point.f =====
rtl/core/dec2fx_pkg.sv
rtl/core/dec2fx_classify.sv
rtl/core/dec2fx_mul10.sv
rtl/core/decimal_text_to_fixed_point.sv
rtl/core/dec2fx_checker.sv
dv/tb_decimal_text_to_fixed_point.sv
